// ===== hdl/mspd_pkg.sv =====
// ---------------------------------------------------------------------------
// mspd_pkg: shared types and constants
// Bit-pair codes, kept byte count and the result record of the Manchester
// sensor packet decoder.
// ---------------------------------------------------------------------------
package mspd_pkg;

  // Manchester bit-pair codes
  localparam logic [1:0] PAIR_ONE  = 2'b10;
  localparam logic [1:0] PAIR_ZERO = 2'b01;

  // Decoded bytes kept per packet
  localparam int KEPT_BYTES = 8;

  // Result field widths
  localparam int ID_W    = 12;
  localparam int WATTS_W = 15;

  // Output tdata width: 61 field bits rounded up to whole bytes
  localparam int OUT_DATA_W = 64;

  // One power channel
  typedef struct packed {
    logic               plugged;
    logic [WATTS_W-1:0] watts;
  } channel_t;

  // One decoded packet result
  typedef struct packed {
    logic            packet_ok;
    logic [ID_W-1:0] sensor_id;
    logic            pairing_request;
    channel_t        ch_one;
    channel_t        ch_two;
    channel_t        ch_three;
  } result_t;

endpackage

// ===== hdl/mspd_nibble_dec.sv =====
// ---------------------------------------------------------------------------
// mspd_nibble_dec: Manchester nibble decoder
// Turns one raw byte of four bit pairs (top pair first) into a nibble and
// flags any illegal pair.
// ---------------------------------------------------------------------------
module mspd_nibble_dec (
  input  logic [7:0] raw_i,
  output logic [3:0] nibble_o,
  output logic       bad_o
);

  // Each pair decodes independently; pair k sits at raw bits [2k+1:2k]
  always_comb begin
    logic [1:0] pair;
    nibble_o = '0;
    bad_o    = 1'b0;
    for (int k = 0; k < 4; k++) begin
      pair = raw_i[2*k +: 2];
      if (pair == mspd_pkg::PAIR_ONE) begin
        nibble_o[k] = 1'b1;
      end else if (pair != mspd_pkg::PAIR_ZERO) begin
        bad_o = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mspd_assemble.sv =====
// ---------------------------------------------------------------------------
// mspd_assemble: packet assembler
// Tracks the raw byte position, joins nibble pairs into decoded bytes,
// collects the pair error and forms the result on the last raw byte.
// ---------------------------------------------------------------------------
module mspd_assemble #(
  parameter int RAW_PACKET_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          raw_i,
  input  logic                start_i,
  output logic                last_o,
  output mspd_pkg::result_t   result_o
);

  localparam int CNT_W = $clog2(RAW_PACKET_BYTES);

  logic [CNT_W-1:0] count_q, count_d;
  logic [3:0]       high_nib_q;
  logic             err_q, err_d;
  logic [7:0]       bytes_q [mspd_pkg::KEPT_BYTES];
  logic [7:0]       bytes_now [mspd_pkg::KEPT_BYTES];

  logic [CNT_W-1:0] idx, idx_half;
  logic [3:0]       nib;
  logic             bad;
  logic             err_acc;
  logic             kept;
  logic             odd;
  logic [2:0]       wr_sel;

  mspd_nibble_dec u_dec (
    .raw_i    (raw_i),
    .nibble_o (nib),
    .bad_o    (bad)
  );

  // Position of this raw byte; a start restarts the packet
  assign idx      = start_i ? '0 : count_q;
  assign idx_half = idx >> 1;
  assign odd      = idx[0];
  assign kept     = idx_half < CNT_W'(mspd_pkg::KEPT_BYTES);
  assign wr_sel   = idx_half[2:0];
  assign last_o   = idx == CNT_W'(RAW_PACKET_BYTES - 1);
  assign err_acc  = (err_q & ~start_i) | bad;

  assign count_d = last_o ? '0 : idx + CNT_W'(1);
  assign err_d   = last_o ? 1'b0 : err_acc;

  // Decoded bytes as they stand after this raw byte
  always_comb begin
    for (int i = 0; i < mspd_pkg::KEPT_BYTES; i++) begin
      if (kept && odd && (wr_sel == 3'(i))) begin
        bytes_now[i] = {high_nib_q, nib};
      end else begin
        bytes_now[i] = bytes_q[i];
      end
    end
  end

  // Result fields, all zero on a bad packet
  always_comb begin
    result_o = '0;
    if (!err_acc) begin
      result_o.packet_ok       = 1'b1;
      result_o.sensor_id       = {bytes_now[0][3:0], bytes_now[1]};
      result_o.pairing_request = bytes_now[0][7];
      result_o.ch_one.plugged  = bytes_now[2][7];
      result_o.ch_two.plugged  = bytes_now[4][7];
      result_o.ch_three.plugged = bytes_now[6][7];
      if (bytes_now[2][7]) begin
        result_o.ch_one.watts = {bytes_now[2][6:0], bytes_now[3]};
      end
      if (bytes_now[4][7]) begin
        result_o.ch_two.watts = {bytes_now[4][6:0], bytes_now[5]};
      end
      if (bytes_now[6][7]) begin
        result_o.ch_three.watts = {bytes_now[6][6:0], bytes_now[7]};
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      err_q      <= 1'b0;
      high_nib_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
      err_q   <= err_d;
      if (!odd) begin
        high_nib_q <= nib;
      end
    end
  end

  // Decoded byte store
  always_ff @(posedge clk_i) begin
    if (advance_i && odd && kept) begin
      bytes_q[wr_sel] <= {high_nib_q, nib};
    end
  end

endmodule

// ===== hdl/manchester_sensor_packet_decoder.sv =====
// ---------------------------------------------------------------------------
// manchester_sensor_packet_decoder: energy sensor packet decoder
// Decodes Manchester-coded raw radio bytes into one sensor result per packet.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one raw radio byte per item, tuser high on the first byte
//   of a packet. Master channel: one item per packet, sent on raw byte
//   RAW_PACKET_BYTES-1; tuser carries the packet health.
//   Throughput: one raw byte per cycle while no last byte waits on a full
//   output slot. Each item sits in the input register, where the nibble decode
//   and assembly run; its result is then loaded into the output register.
//   Reset clears the byte count, held nibble, error flag and the valid flags
//   of both registers.
//   When the receiver stalls, the finished result waits in the output
//   register; raw bytes that make no result keep flowing, and the next last
//   byte waits in the input register until the output slot frees up.
//   After a result the count restarts, so the next byte begins a new packet.
// ---------------------------------------------------------------------------
module manchester_sensor_packet_decoder #(
  parameter int RAW_PACKET_BYTES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Raw byte stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] raw_byte
  input  logic                              s_axis_tuser,  // [0] packet_start
  // Decoded packet stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] sensor_id, [12] pairing_request, [27:13] watts_one,
  // [28] plugged_one, [43:29] watts_two, [44] plugged_two,
  // [59:45] watts_three, [60] plugged_three, [63:61] zero
  output logic [mspd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser   // [0] packet_ok
);

  logic              in_valid_q;
  logic [7:0]        in_raw_q;
  logic              in_start_q;
  logic              out_valid_q;
  mspd_pkg::result_t out_res_q;
  mspd_pkg::result_t res;
  logic              res_last;
  logic              advance;
  logic              load_out;

  // Input item moves on unless it is a last byte facing a full output slot
  assign advance       = in_valid_q & (~res_last | ~out_valid_q | m_axis_tready);
  assign load_out      = advance & res_last;
  assign s_axis_tready = ~in_valid_q | advance;

  mspd_assemble #(
    .RAW_PACKET_BYTES (RAW_PACKET_BYTES)
  ) u_asm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .raw_i     (in_raw_q),
    .start_i   (in_start_q),
    .last_o    (res_last),
    .result_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_raw_q   <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.packet_ok;
  assign m_axis_tdata  = {3'b000,
                          out_res_q.ch_three.plugged, out_res_q.ch_three.watts,
                          out_res_q.ch_two.plugged, out_res_q.ch_two.watts,
                          out_res_q.ch_one.plugged, out_res_q.ch_one.watts,
                          out_res_q.pairing_request, out_res_q.sensor_id};

endmodule
